>>> design/i2c_bus_clear_sequencer_macros.svh
// Assertion macros shared by the bus-clear sequencer RTL.
// No dependencies; expects signals clk and arst_n in the including module.
`ifndef I2C_BUS_CLEAR_SEQUENCER_MACROS_SVH
`define I2C_BUS_CLEAR_SEQUENCER_MACROS_SVH

// check sampled on clk, ignored while reset is asserted
`define IBCS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check sampled on clk, also active during reset
`define IBCS_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/ibcs_pkg.sv
// Package for the I2C bus-clear sequencer: payload structs, phase encoding,
// register indexes, reset values and the duration load helper. No dependencies.
package ibcs_pkg;

	localparam int unsigned CountBits = 16;
	localparam int unsigned CfgBits   = 16;
	localparam int unsigned CfgIdxBits = 2;
	localparam int unsigned PulseBits = 4;

	localparam logic [CountBits-1:0] CountMax = '1;

	typedef enum logic [CfgIdxBits-1:0] {
		REG_SETTLE_TICKS      = 2'd0,
		REG_HALF_PERIOD_TICKS = 2'd1,
		REG_MAX_PULSES        = 2'd2
	} reg_idx_t;

	localparam logic [15:0]          SettleTicksRst = 16'd20;
	localparam logic [15:0]          HalfPeriodRst  = 16'd10;
	localparam logic [PulseBits-1:0] MaxPulsesRst   = 4'd9;

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_SETTLE    = 3'd1,
		PH_LOW       = 3'd2,
		PH_HIGH      = 3'd3,
		PH_STOP_LOW  = 3'd4,
		PH_STOP_HOLD = 3'd5,
		PH_STOP_REL  = 3'd6
	} phase_t;

	typedef struct packed {
		logic start_req;
		logic line_id;
		logic sda_level;
		logic scl_level;
	} in_t;

	typedef struct packed {
		logic scl_value;
		logic scl_driven;
		logic sda_value;
		logic sda_driven;
		logic pair_select;
		logic busy_res;
		logic done_res;
		logic sda_after;
		logic scl_after;
	} out_t;

	// zero acts as one; values beyond the counter range saturate
	function automatic logic [CountBits-1:0] load_count(input logic [15:0] d);
		logic [31:0] v;
		v = 32'(d);
		if (v == 32'd0) v = 32'd1;
		if (v > 32'(CountMax)) return CountMax;
		return CountBits'(v);
	endfunction

endpackage

>>> design/i2c_bus_clear_sequencer.sv
// I2C bus-clear sequencer. Every accepted request is one timer tick and
// produces exactly one result, which shows the line drive, pair select and
// run status after that tick. A request is taken every clock unless stalled:
// state and the result register update in the same cycle, so a result appears
// in the next cycle. The input stalls only while the result register holds an
// untaken result and the output is stalled. A run lasts settle_ticks plus
// 2*half_period_ticks per SCL pulse plus three STOP steps of half_period_ticks.
// Depends on ibcs_pkg and i2c_bus_clear_sequencer_macros.svh.
`include "i2c_bus_clear_sequencer_macros.svh"

module i2c_bus_clear_sequencer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  ibcs_pkg::in_t                 in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output ibcs_pkg::out_t                out_data,
	input  logic                          cfg_we,
	input  logic [ibcs_pkg::CfgIdxBits-1:0] cfg_index,
	input  logic [ibcs_pkg::CfgBits-1:0]  cfg_data
);

	logic [15:0]                       settle_q;
	logic [15:0]                       half_q;
	logic [ibcs_pkg::PulseBits-1:0]    max_pulses_q;

	ibcs_pkg::phase_t                  phase_q, phase_n;
	logic [ibcs_pkg::CountBits-1:0]    wait_q, wait_n;
	logic [ibcs_pkg::PulseBits-1:0]    pulse_q, pulse_n;
	logic                              target_q, target_n;
	logic                              active_q, active_n;
	logic                              lsda_q, lsda_n;
	logic                              lscl_q, lscl_n;
	logic                              done_n;
	logic [ibcs_pkg::PulseBits-1:0]    limit;

	logic                              out_valid_q;
	ibcs_pkg::out_t                    out_q, res;
	logic                              in_acc;

	assign in_stall  = out_valid_q & out_stall;
	assign in_acc    = in_valid & ~in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign limit = (max_pulses_q == '0) ? ibcs_pkg::PulseBits'(1) : max_pulses_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q     <= ibcs_pkg::SettleTicksRst;
			half_q       <= ibcs_pkg::HalfPeriodRst;
			max_pulses_q <= ibcs_pkg::MaxPulsesRst;
		end else if (cfg_we) begin
			case (cfg_index)
				ibcs_pkg::REG_SETTLE_TICKS:      settle_q     <= cfg_data[15:0];
				ibcs_pkg::REG_HALF_PERIOD_TICKS: half_q       <= cfg_data[15:0];
				ibcs_pkg::REG_MAX_PULSES:        max_pulses_q <= cfg_data[ibcs_pkg::PulseBits-1:0];
				default: ;
			endcase
		end
	end

	// next state for one tick
	always_comb begin
		phase_n  = phase_q;
		wait_n   = wait_q;
		pulse_n  = pulse_q;
		target_n = target_q;
		active_n = active_q;
		lsda_n   = lsda_q;
		lscl_n   = lscl_q;
		done_n   = 1'b0;
		if (phase_q == ibcs_pkg::PH_IDLE) begin
			if (in_data.start_req) begin
				target_n = in_data.line_id;
				phase_n  = ibcs_pkg::PH_SETTLE;
				wait_n   = ibcs_pkg::load_count(settle_q);
			end
		end else if (wait_q > ibcs_pkg::CountBits'(1)) begin
			wait_n = wait_q - ibcs_pkg::CountBits'(1);
		end else begin
			wait_n = ibcs_pkg::load_count(half_q);
			unique case (phase_q)
				ibcs_pkg::PH_SETTLE: begin
					pulse_n = '0;
					phase_n = ibcs_pkg::PH_LOW;
				end
				ibcs_pkg::PH_LOW: begin
					phase_n = ibcs_pkg::PH_HIGH;
				end
				ibcs_pkg::PH_HIGH: begin
					pulse_n = pulse_q + ibcs_pkg::PulseBits'(1);
					// stop once SDA is released or the pulse budget is spent
					if (in_data.sda_level || pulse_n >= limit)
						phase_n = ibcs_pkg::PH_STOP_LOW;
					else
						phase_n = ibcs_pkg::PH_LOW;
				end
				ibcs_pkg::PH_STOP_LOW: begin
					phase_n = ibcs_pkg::PH_STOP_HOLD;
				end
				ibcs_pkg::PH_STOP_HOLD: begin
					phase_n = ibcs_pkg::PH_STOP_REL;
				end
				default: begin
					lsda_n   = in_data.sda_level;
					lscl_n   = in_data.scl_level;
					active_n = target_q;
					phase_n  = ibcs_pkg::PH_IDLE;
					wait_n   = '0;
					done_n   = 1'b1;
				end
			endcase
		end
	end

	// line drive follows the phase after the tick
	always_comb begin
		res = '0;
		unique case (phase_n)
			ibcs_pkg::PH_SETTLE, ibcs_pkg::PH_HIGH: begin
				res.scl_value  = 1'b1;
				res.scl_driven = 1'b1;
			end
			ibcs_pkg::PH_LOW: begin
				res.scl_driven = 1'b1;
			end
			ibcs_pkg::PH_STOP_LOW, ibcs_pkg::PH_STOP_HOLD: begin
				res.scl_value  = 1'b1;
				res.scl_driven = 1'b1;
				res.sda_driven = 1'b1;
			end
			ibcs_pkg::PH_STOP_REL: begin
				res.scl_value  = 1'b1;
				res.scl_driven = 1'b1;
				res.sda_value  = 1'b1;
				res.sda_driven = 1'b1;
			end
			default: ;
		endcase
		res.pair_select = active_n;
		res.busy_res    = (phase_n != ibcs_pkg::PH_IDLE);
		res.done_res    = done_n;
		res.sda_after   = lsda_n;
		res.scl_after   = lscl_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= ibcs_pkg::PH_IDLE;
			wait_q   <= '0;
			pulse_q  <= '0;
			target_q <= 1'b0;
			active_q <= 1'b0;
			lsda_q   <= 1'b0;
			lscl_q   <= 1'b0;
		end else if (in_acc) begin
			phase_q  <= phase_n;
			wait_q   <= wait_n;
			pulse_q  <= pulse_n;
			target_q <= target_n;
			active_q <= active_n;
			lsda_q   <= lsda_n;
			lscl_q   <= lscl_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= in_acc | (out_valid_q & out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			out_q <= res;
		end
	end

	`IBCS_ASSERT(a_wait_nonzero_busy, (phase_q != ibcs_pkg::PH_IDLE) |-> (wait_q != '0), "wait counter empty while busy")
	`IBCS_ASSERT(a_start_settle, (in_acc && phase_q == ibcs_pkg::PH_IDLE && in_data.start_req) |=> (phase_q == ibcs_pkg::PH_SETTLE), "start request did not begin settle")
	`IBCS_ASSERT(a_done_released, (out_valid_q && out_q.done_res) |-> (!out_q.busy_res && !out_q.scl_driven && !out_q.sda_driven), "done while lines still held")
	`IBCS_ASSERT(a_empty_no_stall, !out_valid_q |-> !in_stall, "input stalled with empty result register")

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the I2C bus-clear sequencer: each request is one tick whose
// predicted line drive and run status are checked against the block's results.
// Depends on ibcs_pkg and the i2c_bus_clear_sequencer RTL.
`timescale 1ns / 1ps

module tb_top;

	localparam logic [ibcs_pkg::CfgIdxBits-1:0] RegSpare = 2'd3;

	// Predicts the line drive of every tick and holds the results still to come.
	class line_drive_board;
		ibcs_pkg::phase_t ph;
		logic [15:0]    wait_cnt;
		logic [3:0]     pulses;
		logic           target_pair;
		logic           given_pair;
		logic           sda_seen;
		logic           scl_seen;
		logic [15:0]    settle_cfg;
		logic [15:0]    half_cfg;
		logic [3:0]     pulse_cfg;
		ibcs_pkg::out_t drive_q[$];
		int             errors;
		string          field_names[9] = '{"scl_value", "scl_driven", "sda_value", "sda_driven",
			"pair_select", "busy_res", "done_res", "sda_after", "scl_after"};

		function new();
			ph = ibcs_pkg::PH_IDLE;
			wait_cnt = '0;
			pulses = '0;
			target_pair = 1'b0;
			given_pair = 1'b0;
			sda_seen = 1'b0;
			scl_seen = 1'b0;
			settle_cfg = 16'd20;
			half_cfg = 16'd10;
			pulse_cfg = 4'd9;
			errors = 0;
		endfunction

		// zero counts as one tick; a 16-bit counter holds any 16-bit duration
		function logic [15:0] ticks_of(logic [15:0] d);
			return (d == 16'd0) ? 16'd1 : d;
		endfunction

		function void set_reg(logic [ibcs_pkg::CfgIdxBits-1:0] idx, logic [15:0] v);
			case (idx)
				ibcs_pkg::REG_SETTLE_TICKS: settle_cfg = v;
				ibcs_pkg::REG_HALF_PERIOD_TICKS: half_cfg = v;
				ibcs_pkg::REG_MAX_PULSES: pulse_cfg = v[3:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return drive_q.size();
		endfunction

		function void take_tick(ibcs_pkg::in_t t);
			logic [3:0]     lim;
			logic           done;
			ibcs_pkg::out_t w;
			lim = (pulse_cfg == 4'd0) ? 4'd1 : pulse_cfg;
			done = 1'b0;
			if (ph == ibcs_pkg::PH_IDLE) begin
				if (t.start_req) begin
					target_pair = t.line_id;
					ph = ibcs_pkg::PH_SETTLE;
					wait_cnt = ticks_of(settle_cfg);
				end
			end else if (wait_cnt > 16'd1) begin
				wait_cnt = wait_cnt - 16'd1;
			end else begin
				wait_cnt = ticks_of(half_cfg);
				case (ph)
					ibcs_pkg::PH_SETTLE: begin
						pulses = '0;
						ph = ibcs_pkg::PH_LOW;
					end
					ibcs_pkg::PH_LOW: ph = ibcs_pkg::PH_HIGH;
					ibcs_pkg::PH_HIGH: begin
						pulses = pulses + 4'd1;
						// early stop once SDA is seen released at the end of a high phase
						ph = (t.sda_level || pulses >= lim) ? ibcs_pkg::PH_STOP_LOW
							: ibcs_pkg::PH_LOW;
					end
					ibcs_pkg::PH_STOP_LOW: ph = ibcs_pkg::PH_STOP_HOLD;
					ibcs_pkg::PH_STOP_HOLD: ph = ibcs_pkg::PH_STOP_REL;
					default: begin
						sda_seen = t.sda_level;
						scl_seen = t.scl_level;
						given_pair = target_pair;
						ph = ibcs_pkg::PH_IDLE;
						wait_cnt = '0;
						done = 1'b1;
					end
				endcase
			end
			w = '0;
			case (ph)
				ibcs_pkg::PH_SETTLE, ibcs_pkg::PH_HIGH: begin
					w.scl_value = 1'b1;
					w.scl_driven = 1'b1;
				end
				ibcs_pkg::PH_LOW: w.scl_driven = 1'b1;
				ibcs_pkg::PH_STOP_LOW, ibcs_pkg::PH_STOP_HOLD: begin
					w.scl_value = 1'b1;
					w.scl_driven = 1'b1;
					w.sda_driven = 1'b1;
				end
				ibcs_pkg::PH_STOP_REL: begin
					w.scl_value = 1'b1;
					w.scl_driven = 1'b1;
					w.sda_value = 1'b1;
					w.sda_driven = 1'b1;
				end
				default: ;
			endcase
			w.pair_select = given_pair;
			w.busy_res = (ph != ibcs_pkg::PH_IDLE);
			w.done_res = done;
			w.sda_after = sda_seen;
			w.scl_after = scl_seen;
			drive_q.push_back(w);
		endfunction

		task report(string msg);
			$display("ERROR at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_drive(ibcs_pkg::out_t got);
			ibcs_pkg::out_t want;
			if (drive_q.size() == 0) begin
				report($sformatf("result %b with no request waiting", got));
			end else begin
				want = drive_q.pop_front();
				for (int i = 8; i >= 0; i--) begin
					if (got[i] !== want[i])
						report($sformatf("%s got %b want %b", field_names[8-i], got[i], want[i]));
				end
			end
		endtask
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_stall;
	ibcs_pkg::in_t                   in_data;
	logic                            out_valid;
	logic                            out_stall;
	ibcs_pkg::out_t                  out_data;
	logic                            cfg_we;
	logic [ibcs_pkg::CfgIdxBits-1:0] cfg_index;
	logic [ibcs_pkg::CfgBits-1:0]    cfg_data;

	line_drive_board board = new();
	int stall_pct = 0;

	i2c_bus_clear_sequencer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// results come in the cycle after their request, so check before noting
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				board.check_drive(out_data);
			if (in_valid && !in_stall)
				board.take_tick(in_data);
		end
	end

	function automatic ibcs_pkg::in_t rand_tick();
		ibcs_pkg::in_t t;
		int            sda_pct;
		// mostly a stuck SDA so runs go the full pulse count; some noise
		sda_pct = ($urandom_range(4) == 0) ? 50 : 10;
		t.start_req = ($urandom_range(3) == 0);
		t.line_id = 1'($urandom_range(1));
		t.sda_level = ($urandom_range(99) < sda_pct);
		t.scl_level = 1'($urandom_range(1));
		return t;
	endfunction

	task automatic send_tick(ibcs_pkg::in_t t, int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= t;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (board.pending() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(logic [ibcs_pkg::CfgIdxBits-1:0] idx, logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		board.set_reg(idx, v);
		@(negedge clk);
	endtask

	task automatic configure(logic [15:0] settle, logic [15:0] half, logic [15:0] pulses);
		drain_results();
		write_reg(ibcs_pkg::REG_SETTLE_TICKS, settle);
		write_reg(ibcs_pkg::REG_HALF_PERIOD_TICKS, half);
		write_reg(ibcs_pkg::REG_MAX_PULSES, pulses);
		cfg_we <= 1'b0;
	endtask

	task automatic run_ticks(int n, int idle_pct, int pause_at);
		for (int i = 0; i < n; i++) begin
			if (i == pause_at)
				drain_results();
			send_tick(rand_tick(), idle_pct);
		end
	endtask

	initial begin
		// {start_req, line_id, sda_level, scl_level}
		logic [3:0] directed[12];
		directed = '{4'b0000, 4'b0111, 4'b0101, 4'b0010, 4'b1100, 4'b1000,
			4'b1011, 4'b1111, 4'b0001, 4'b0110, 4'b0000, 4'b0011};
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset values; second start comes while busy and must be ignored
		foreach (directed[i])
			send_tick(ibcs_pkg::in_t'(directed[i]), 0);
		stall_pct = 0;
		run_ticks(250, 0, -1);

		// zero durations and zero pulse limit (upper bits of the limit are cut)
		configure(16'd0, 16'd0, 16'hFFF0);
		@(negedge clk);
		write_reg(RegSpare, 16'h0003);
		cfg_we <= 1'b0;
		stall_pct = 0;
		run_ticks(200, 49, -1);

		configure(16'd3, 16'd2, 16'h000F);
		stall_pct = 49;
		run_ticks(200, 0, 100);

		configure(16'd1, 16'd1, 16'd1);
		stall_pct = 17;
		run_ticks(150, 17, -1);

		configure(16'd7, 16'd3, 16'h5A37);
		stall_pct = 0;
		run_ticks(150, 0, -1);

		drain_results();
		if (board.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
